// ===== hw/rtl/sccl_pkg.sv =====
package sccl_pkg;

	localparam int MAX_NODES   = 1024;
	localparam int MAX_EDGES   = 4096;
	localparam int WEIGHT_BITS = 16;
	localparam int SUM_W       = 32;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int CNT_W       = NODE_W + 1;
	localparam int EDGE_AW     = $clog2(MAX_EDGES);
	localparam int POS_W       = EDGE_AW + 1;

	typedef enum logic [1:0] {
		REQ_WEIGHT = 2'd0,
		REQ_EDGE   = 2'd1,
		REQ_RUN    = 2'd2
	} req_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CLR,
		S_CNT_RD, S_CNT_EV, S_CNT_UPD,
		S_PFX_RD, S_PFX_WR,
		S_FIL_RD, S_FIL_EV, S_FIL_UPD,
		S_ROOT_RD, S_ROOT_EV, S_PUSH,
		S_WALK, S_W_ADJ, S_W_V, S_W_PB,
		S_MP_RD, S_MP_EV, S_MP_ACC, S_MP_END,
		S_RET, S_RET_WK, S_RET_ND,
		S_EMIT
	} state_t;

	// per-node work record
	typedef struct packed {
		logic [POS_W-1:0] cnt;
		logic [CNT_W-1:0] visit;
		logic [CNT_W-1:0] low;
		logic [CNT_W-1:0] cid;
		logic [SUM_W-1:0] ob;
	} node_rec_t;

	typedef struct packed {
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
	} edge_rec_t;

	typedef struct packed {
		logic [NODE_W-1:0] node_idx;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  lim;
	} walk_ent_t;

	localparam int NODE_REC_W = $bits(node_rec_t);
	localparam int EDGE_REC_W = $bits(edge_rec_t);
	localparam int WALK_W     = $bits(walk_ent_t);

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/scc_condense_longest_path_core.sv =====
// Heaviest path through the condensation of a weighted directed graph.
// Weight and edge loads are accepted only while idle, one transfer per cycle.
// Compute: run time is set by the single read port of the node record memory, which is
// visited once per step of the walk.
// Reset clears control state and the edge count; node weights survive and must be
// written before use. The result strobe lasts one cycle; the receiver cannot stall.
module scc_condense_longest_path_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [10:0] node,
	input  logic [15:0] weight,
	input  logic [10:0] dest,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	output logic        done,
	output logic [31:0] best_sum,
	output logic        dropped_edges
);

	localparam int NW = sccl_pkg::NODE_W;
	localparam int CW = sccl_pkg::CNT_W;
	localparam int PW = sccl_pkg::POS_W;
	localparam int EW = sccl_pkg::EDGE_AW;
	localparam int SW = sccl_pkg::SUM_W;
	localparam int WB = sccl_pkg::WEIGHT_BITS;

	sccl_pkg::state_t state_q, state_d;

	// control registers
	logic [CW-1:0] cfg_q;
	logic [PW-1:0] etot_q;
	logic          rej_q;
	logic [CW-1:0] n_q;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] nvalid_q;
	logic [PW-1:0] acc_q;
	logic [CW-1:0] dfn_q;
	logic [CW-1:0] wsp_q;
	logic [CW-1:0] msp_q;
	logic [CW-1:0] ncomp_q;
	logic          formed_q;
	logic          done_q;

	// work registers
	logic [NW-1:0] es_q, ed_q, v_q, w_q;
	logic [PW-1:0] vcnt_q;
	logic [NW-1:0] top_u_q;
	logic [PW-1:0] top_pos_q, top_lim_q, top_cnt_q;
	logic [CW-1:0] top_visit_q, top_low_q, cl_q;
	logic [SW-1:0] top_ob_q, sum_q, mob_q, best_q, ret_q;
	logic [SW-1:0] best_sum_q;
	logic          dropped_q;

	// memory ports
	logic                   wt_we;
	logic [NW-1:0]          wt_waddr, wt_raddr;
	logic [WB-1:0]          wt_wdata, wt_rd;
	logic                   edg_we;
	logic [EW-1:0]          edg_waddr, edg_raddr;
	sccl_pkg::edge_rec_t    edg_wdata, ed_rd;
	logic                   nd_we;
	logic [NW-1:0]          nd_waddr, nd_raddr;
	sccl_pkg::node_rec_t    nd_wdata, nd_rd;
	logic                   adj_we;
	logic [EW-1:0]          adj_waddr, adj_raddr;
	logic [NW-1:0]          adj_wdata, adj_rd;
	logic                   wk_we;
	logic [NW-1:0]          wk_waddr, wk_raddr;
	sccl_pkg::walk_ent_t    wk_wdata, wk_rd;
	logic                   mb_we;
	logic [NW-1:0]          mb_waddr, mb_raddr, mb_wdata, mb_rd;
	logic                   pb_we;
	logic [NW-1:0]          pb_waddr, pb_raddr;
	logic [SW-1:0]          pb_wdata, pb_rd;

	// helpers
	logic [CW-1:0] n_now, n_last;
	logic          accept, node_ok, dest_ok, edge_room, edg_ok, last_k;
	logic [PW-1:0] push_lim, fill_pos;
	logic [CW-1:0] dfn_nx, wsp_m1, wsp_m2, msp_m1, cid_m1;
	logic [SW-1:0] mp_sum, mp_obw, total;
	logic          walk_more, is_root_pop;

	assign n_now     = (cfg_q > CW'(sccl_pkg::MAX_NODES)) ? CW'(sccl_pkg::MAX_NODES) : cfg_q;
	assign n_last    = n_q - 1'b1;
	assign accept    = start && (state_q == sccl_pkg::S_IDLE);
	assign node_ok   = (node != '0) && (node <= n_now);
	assign dest_ok   = (dest != '0) && (dest <= n_now);
	assign edge_room = etot_q < PW'(sccl_pkg::MAX_EDGES);
	assign edg_ok    = ({1'b0, ed_rd.src} < n_q) && ({1'b0, ed_rd.dst} < n_q);
	assign last_k    = idx_q[CW-1:0] == n_last;
	assign push_lim  = (v_q == n_last[NW-1:0]) ? nvalid_q : nd_rd.cnt;
	assign fill_pos  = nd_rd.cnt - 1'b1;
	assign dfn_nx    = dfn_q + 1'b1;
	assign wsp_m1    = wsp_q - 1'b1;
	assign wsp_m2    = wsp_q - 2'd2;
	assign msp_m1    = msp_q - 1'b1;
	assign cid_m1    = nd_rd.cid - 1'b1;
	assign mp_sum    = sccl_pkg::sat_add(sum_q, SW'(wt_rd));
	assign mp_obw    = (w_q == top_u_q) ? top_ob_q : nd_rd.ob;
	assign total     = sccl_pkg::sat_add(sum_q, mob_q);
	assign walk_more = top_pos_q < top_lim_q;
	assign is_root_pop = top_low_q == top_visit_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sccl_pkg::S_IDLE: begin
				if (accept && req_type == sccl_pkg::REQ_RUN) begin
					state_d = (n_now == '0) ? sccl_pkg::S_EMIT : sccl_pkg::S_CLR;
				end
			end
			sccl_pkg::S_CLR:     state_d = last_k ? sccl_pkg::S_CNT_RD : sccl_pkg::S_CLR;
			sccl_pkg::S_CNT_RD:  state_d = (idx_q == etot_q) ? sccl_pkg::S_PFX_RD
				: sccl_pkg::S_CNT_EV;
			sccl_pkg::S_CNT_EV:  state_d = edg_ok ? sccl_pkg::S_CNT_UPD : sccl_pkg::S_CNT_RD;
			sccl_pkg::S_CNT_UPD: state_d = sccl_pkg::S_CNT_RD;
			sccl_pkg::S_PFX_RD:  state_d = sccl_pkg::S_PFX_WR;
			sccl_pkg::S_PFX_WR:  state_d = last_k ? sccl_pkg::S_FIL_RD : sccl_pkg::S_PFX_RD;
			sccl_pkg::S_FIL_RD:  state_d = (idx_q == etot_q) ? sccl_pkg::S_ROOT_RD
				: sccl_pkg::S_FIL_EV;
			sccl_pkg::S_FIL_EV:  state_d = edg_ok ? sccl_pkg::S_FIL_UPD : sccl_pkg::S_FIL_RD;
			sccl_pkg::S_FIL_UPD: state_d = sccl_pkg::S_FIL_RD;
			sccl_pkg::S_ROOT_RD: state_d = sccl_pkg::S_ROOT_EV;
			sccl_pkg::S_ROOT_EV: begin
				if (nd_rd.visit != '0) begin
					state_d = last_k ? sccl_pkg::S_EMIT : sccl_pkg::S_ROOT_RD;
				end else begin
					state_d = sccl_pkg::S_PUSH;
				end
			end
			sccl_pkg::S_PUSH:    state_d = sccl_pkg::S_WALK;
			sccl_pkg::S_WALK: begin
				if (walk_more) begin
					state_d = sccl_pkg::S_W_ADJ;
				end else if (is_root_pop) begin
					state_d = sccl_pkg::S_MP_RD;
				end else begin
					state_d = sccl_pkg::S_RET;
				end
			end
			sccl_pkg::S_W_ADJ:   state_d = sccl_pkg::S_W_V;
			sccl_pkg::S_W_V: begin
				if (nd_rd.visit == '0) begin
					state_d = sccl_pkg::S_PUSH;
				end else if (nd_rd.cid == '0) begin
					state_d = sccl_pkg::S_WALK;
				end else begin
					state_d = sccl_pkg::S_W_PB;
				end
			end
			sccl_pkg::S_W_PB:    state_d = sccl_pkg::S_WALK;
			sccl_pkg::S_MP_RD:   state_d = sccl_pkg::S_MP_EV;
			sccl_pkg::S_MP_EV:   state_d = sccl_pkg::S_MP_ACC;
			sccl_pkg::S_MP_ACC:  state_d = (w_q == top_u_q) ? sccl_pkg::S_MP_END
				: sccl_pkg::S_MP_RD;
			sccl_pkg::S_MP_END:  state_d = sccl_pkg::S_RET;
			sccl_pkg::S_RET: begin
				if (wsp_q == CW'(1)) begin
					state_d = last_k ? sccl_pkg::S_EMIT : sccl_pkg::S_ROOT_RD;
				end else begin
					state_d = sccl_pkg::S_RET_WK;
				end
			end
			sccl_pkg::S_RET_WK:  state_d = sccl_pkg::S_RET_ND;
			sccl_pkg::S_RET_ND:  state_d = sccl_pkg::S_WALK;
			sccl_pkg::S_EMIT:    state_d = sccl_pkg::S_IDLE;
			default:             state_d = sccl_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		wt_we = 1'b0;  wt_waddr = '0;  wt_wdata = '0;  wt_raddr = '0;
		edg_we = 1'b0; edg_waddr = '0; edg_wdata = '0; edg_raddr = '0;
		nd_we = 1'b0;  nd_waddr = '0;  nd_wdata = '0;  nd_raddr = '0;
		adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0; adj_raddr = '0;
		wk_we = 1'b0;  wk_waddr = '0;  wk_wdata = '0;  wk_raddr = '0;
		mb_we = 1'b0;  mb_waddr = '0;  mb_wdata = '0;  mb_raddr = '0;
		pb_we = 1'b0;  pb_waddr = '0;  pb_wdata = '0;  pb_raddr = '0;
		case (state_q)
			sccl_pkg::S_IDLE: begin
				if (accept && req_type == sccl_pkg::REQ_WEIGHT && node_ok) begin
					wt_we    = 1'b1;
					wt_waddr = NW'(node - 1'b1);
					wt_wdata = weight;
				end
				if (accept && req_type == sccl_pkg::REQ_EDGE && node_ok && dest_ok
						&& edge_room) begin
					edg_we        = 1'b1;
					edg_waddr     = etot_q[EW-1:0];
					edg_wdata.src = NW'(node - 1'b1);
					edg_wdata.dst = NW'(dest - 1'b1);
				end
			end
			sccl_pkg::S_CLR: begin
				nd_we    = 1'b1;
				nd_waddr = idx_q[NW-1:0];
			end
			sccl_pkg::S_CNT_RD, sccl_pkg::S_FIL_RD: begin
				edg_raddr = idx_q[EW-1:0];
			end
			sccl_pkg::S_CNT_EV, sccl_pkg::S_FIL_EV: begin
				nd_raddr = ed_rd.src;
			end
			sccl_pkg::S_CNT_UPD: begin
				nd_we        = 1'b1;
				nd_waddr     = es_q;
				nd_wdata     = nd_rd;
				nd_wdata.cnt = nd_rd.cnt + 1'b1;
			end
			sccl_pkg::S_PFX_RD: begin
				nd_raddr = idx_q[NW-1:0];
			end
			sccl_pkg::S_PFX_WR: begin
				nd_we        = 1'b1;
				nd_waddr     = idx_q[NW-1:0];
				nd_wdata     = nd_rd;
				nd_wdata.cnt = acc_q + nd_rd.cnt;
			end
			sccl_pkg::S_FIL_UPD: begin
				nd_we        = 1'b1;
				nd_waddr     = es_q;
				nd_wdata     = nd_rd;
				nd_wdata.cnt = fill_pos;
				adj_we       = 1'b1;
				adj_waddr    = fill_pos[EW-1:0];
				adj_wdata    = ed_q;
			end
			sccl_pkg::S_ROOT_RD: begin
				nd_raddr = idx_q[NW-1:0];
			end
			sccl_pkg::S_ROOT_EV: begin
				nd_raddr = idx_q[NW-1:0] + 1'b1;
			end
			sccl_pkg::S_PUSH: begin
				nd_we          = 1'b1;
				nd_waddr       = v_q;
				nd_wdata.cnt   = vcnt_q;
				nd_wdata.visit = dfn_nx;
				nd_wdata.low   = dfn_nx;
				mb_we          = 1'b1;
				mb_waddr       = msp_q[NW-1:0];
				mb_wdata       = v_q;
			end
			sccl_pkg::S_WALK: begin
				adj_raddr = top_pos_q[EW-1:0];
				if (!walk_more && !is_root_pop) begin
					// keep low link and successor best of a node that stays on the stack
					nd_we          = 1'b1;
					nd_waddr       = top_u_q;
					nd_wdata.cnt   = top_cnt_q;
					nd_wdata.visit = top_visit_q;
					nd_wdata.low   = top_low_q;
					nd_wdata.ob    = top_ob_q;
				end
			end
			sccl_pkg::S_W_ADJ: begin
				nd_raddr = adj_rd;
			end
			sccl_pkg::S_W_V: begin
				if (nd_rd.visit == '0) begin
					nd_we          = 1'b1;
					nd_waddr       = top_u_q;
					nd_wdata.cnt   = top_cnt_q;
					nd_wdata.visit = top_visit_q;
					nd_wdata.low   = top_low_q;
					nd_wdata.ob    = top_ob_q;
					wk_we             = 1'b1;
					wk_waddr          = wsp_m1[NW-1:0];
					wk_wdata.node_idx = top_u_q;
					wk_wdata.pos      = top_pos_q;
					wk_wdata.lim      = top_lim_q;
					nd_raddr          = v_q + 1'b1;
				end else begin
					pb_raddr = cid_m1[NW-1:0];
				end
			end
			sccl_pkg::S_MP_RD: begin
				mb_raddr = msp_m1[NW-1:0];
			end
			sccl_pkg::S_MP_EV: begin
				nd_raddr = mb_rd;
				wt_raddr = mb_rd;
			end
			sccl_pkg::S_MP_ACC: begin
				nd_we        = 1'b1;
				nd_waddr     = w_q;
				nd_wdata     = nd_rd;
				nd_wdata.cid = ncomp_q + 1'b1;
			end
			sccl_pkg::S_MP_END: begin
				pb_we    = 1'b1;
				pb_waddr = ncomp_q[NW-1:0];
				pb_wdata = total;
			end
			sccl_pkg::S_RET: begin
				wk_raddr = wsp_m2[NW-1:0];
			end
			sccl_pkg::S_RET_WK: begin
				nd_raddr = wk_rd.node_idx;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sccl_pkg::S_IDLE;
			cfg_q    <= CW'(1);
			etot_q   <= '0;
			rej_q    <= 1'b0;
			n_q      <= '0;
			idx_q    <= '0;
			nvalid_q <= '0;
			acc_q    <= '0;
			dfn_q    <= '0;
			wsp_q    <= '0;
			msp_q    <= '0;
			ncomp_q  <= '0;
			formed_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == sccl_pkg::S_EMIT;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			case (state_q)
				sccl_pkg::S_IDLE: begin
					if (accept) begin
						case (req_type)
							sccl_pkg::REQ_EDGE: begin
								if (node_ok && dest_ok && edge_room) begin
									etot_q <= etot_q + 1'b1;
								end else begin
									rej_q <= 1'b1;
								end
							end
							sccl_pkg::REQ_RUN: begin
								n_q      <= n_now;
								idx_q    <= '0;
								nvalid_q <= '0;
								dfn_q    <= '0;
								wsp_q    <= '0;
								msp_q    <= '0;
								ncomp_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				sccl_pkg::S_CLR: begin
					idx_q <= last_k ? '0 : idx_q + 1'b1;
				end
				sccl_pkg::S_CNT_RD, sccl_pkg::S_FIL_RD: begin
					if (idx_q == etot_q) begin
						idx_q <= '0;
						acc_q <= '0;
					end
				end
				sccl_pkg::S_CNT_EV, sccl_pkg::S_FIL_EV: begin
					if (!edg_ok) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				sccl_pkg::S_CNT_UPD: begin
					nvalid_q <= nvalid_q + 1'b1;
					idx_q    <= idx_q + 1'b1;
				end
				sccl_pkg::S_PFX_WR: begin
					acc_q <= acc_q + nd_rd.cnt;
					idx_q <= last_k ? '0 : idx_q + 1'b1;
				end
				sccl_pkg::S_FIL_UPD: begin
					idx_q <= idx_q + 1'b1;
				end
				sccl_pkg::S_ROOT_EV: begin
					if (nd_rd.visit != '0 && !last_k) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				sccl_pkg::S_PUSH: begin
					dfn_q <= dfn_nx;
					wsp_q <= wsp_q + 1'b1;
					msp_q <= msp_q + 1'b1;
				end
				sccl_pkg::S_WALK: begin
					if (!walk_more && !is_root_pop) begin
						formed_q <= 1'b0;
					end
				end
				sccl_pkg::S_MP_RD: begin
					msp_q <= msp_m1;
				end
				sccl_pkg::S_MP_END: begin
					ncomp_q  <= ncomp_q + 1'b1;
					formed_q <= 1'b1;
				end
				sccl_pkg::S_RET: begin
					wsp_q <= wsp_m1;
					if (wsp_q == CW'(1) && !last_k) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				sccl_pkg::S_EMIT: begin
					etot_q <= '0;
					rej_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// work registers: top of the walk stack lives here, the rest in memory
	always_ff @(posedge clk) begin
		case (state_q)
			sccl_pkg::S_IDLE: begin
				best_q <= '0;
			end
			sccl_pkg::S_CNT_EV, sccl_pkg::S_FIL_EV: begin
				es_q <= ed_rd.src;
				ed_q <= ed_rd.dst;
			end
			sccl_pkg::S_ROOT_EV: begin
				v_q    <= idx_q[NW-1:0];
				vcnt_q <= nd_rd.cnt;
			end
			sccl_pkg::S_PUSH: begin
				top_u_q     <= v_q;
				top_pos_q   <= vcnt_q;
				top_lim_q   <= push_lim;
				top_cnt_q   <= vcnt_q;
				top_visit_q <= dfn_nx;
				top_low_q   <= dfn_nx;
				top_ob_q    <= '0;
			end
			sccl_pkg::S_WALK: begin
				if (walk_more) begin
					top_pos_q <= top_pos_q + 1'b1;
				end else if (is_root_pop) begin
					sum_q <= '0;
					mob_q <= '0;
				end
			end
			sccl_pkg::S_W_ADJ: begin
				v_q <= adj_rd;
			end
			sccl_pkg::S_W_V: begin
				if (nd_rd.visit == '0) begin
					vcnt_q <= nd_rd.cnt;
				end else if (nd_rd.cid == '0 && nd_rd.visit < top_low_q) begin
					top_low_q <= nd_rd.visit;
				end
			end
			sccl_pkg::S_W_PB: begin
				if (pb_rd > top_ob_q) begin
					top_ob_q <= pb_rd;
				end
			end
			sccl_pkg::S_MP_EV: begin
				w_q <= mb_rd;
			end
			sccl_pkg::S_MP_ACC: begin
				sum_q <= mp_sum;
				if (mp_obw > mob_q) begin
					mob_q <= mp_obw;
				end
			end
			sccl_pkg::S_MP_END: begin
				ret_q <= total;
				if (total > best_q) begin
					best_q <= total;
				end
			end
			sccl_pkg::S_RET: begin
				cl_q <= top_low_q;
			end
			sccl_pkg::S_RET_WK: begin
				top_u_q   <= wk_rd.node_idx;
				top_pos_q <= wk_rd.pos;
				top_lim_q <= wk_rd.lim;
			end
			sccl_pkg::S_RET_ND: begin
				top_visit_q <= nd_rd.visit;
				top_cnt_q   <= nd_rd.cnt;
				if (formed_q) begin
					top_low_q <= nd_rd.low;
					top_ob_q  <= (ret_q > nd_rd.ob) ? ret_q : nd_rd.ob;
				end else begin
					top_low_q <= (cl_q < nd_rd.low) ? cl_q : nd_rd.low;
					top_ob_q  <= nd_rd.ob;
				end
			end
			sccl_pkg::S_EMIT: begin
				best_sum_q <= best_q;
				dropped_q  <= rej_q;
			end
			default: begin
			end
		endcase
	end

	assign busy          = state_q != sccl_pkg::S_IDLE;
	assign done          = done_q;
	assign best_sum      = best_sum_q;
	assign dropped_edges = dropped_q;

	sccl_ram #(.WIDTH(WB), .DEPTH(sccl_pkg::MAX_NODES)) u_wt_ram (
		.clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
		.raddr(wt_raddr), .rdata(wt_rd)
	);

	sccl_ram #(.WIDTH(sccl_pkg::EDGE_REC_W), .DEPTH(sccl_pkg::MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
		.raddr(edg_raddr), .rdata(ed_rd)
	);

	sccl_ram #(.WIDTH(sccl_pkg::NODE_REC_W), .DEPTH(sccl_pkg::MAX_NODES)) u_node_ram (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rd)
	);

	sccl_ram #(.WIDTH(NW), .DEPTH(sccl_pkg::MAX_EDGES)) u_adj_ram (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rd)
	);

	sccl_ram #(.WIDTH(sccl_pkg::WALK_W), .DEPTH(sccl_pkg::MAX_NODES)) u_walk_ram (
		.clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
		.raddr(wk_raddr), .rdata(wk_rd)
	);

	sccl_ram #(.WIDTH(NW), .DEPTH(sccl_pkg::MAX_NODES)) u_member_ram (
		.clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata),
		.raddr(mb_raddr), .rdata(mb_rd)
	);

	sccl_ram #(.WIDTH(SW), .DEPTH(sccl_pkg::MAX_NODES)) u_pbest_ram (
		.clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
		.raddr(pb_raddr), .rdata(pb_rd)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == sccl_pkg::S_IDLE)
		else $error("result strobe outside idle");
	a_wsp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wsp_q <= CW'(sccl_pkg::MAX_NODES))
		else $error("walk stack overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sccl_pkg::S_PUSH |-> dfn_q < n_q)
		else $error("visit number past node count");
	a_etot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		etot_q <= PW'(sccl_pkg::MAX_EDGES))
		else $error("edge count overflow");
`endif

endmodule

// ===== hw/rtl/sccl_ram.sv =====
module sccl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
